[rtl/ddd_pkg.sv]
// ddd_pkg: shared widths, constants and calendar tables for date_difference_in_days
// no dependencies
package ddd_pkg;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int CNT_W  = 22;
	localparam int DN_W   = 23;
	localparam int QUO_W  = 8;
	localparam int PROD_W = 27;

	localparam int MAX_YEAR = 9999;

	// reciprocal of 100 as 5243 / 2^19, exact for every 14-bit operand
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [MON_W-1:0] MON_JAN = 4'd1;
	localparam logic [MON_W-1:0] MON_FEB = 4'd2;
	localparam logic [MON_W-1:0] MON_MAR = 4'd3;
	localparam logic [MON_W-1:0] MON_APR = 4'd4;
	localparam logic [MON_W-1:0] MON_MAY = 4'd5;
	localparam logic [MON_W-1:0] MON_JUN = 4'd6;
	localparam logic [MON_W-1:0] MON_JUL = 4'd7;
	localparam logic [MON_W-1:0] MON_AUG = 4'd8;
	localparam logic [MON_W-1:0] MON_SEP = 4'd9;
	localparam logic [MON_W-1:0] MON_OCT = 4'd10;
	localparam logic [MON_W-1:0] MON_NOV = 4'd11;
	localparam logic [MON_W-1:0] MON_DEC = 4'd12;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} ddd_stage_en_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			MON_FEB: len = leap ? 5'd29 : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [MON_W-1:0] m);
		logic [8:0] n;
		unique case (m)
			MON_FEB: n = 9'd31;
			MON_MAR: n = 9'd59;
			MON_APR: n = 9'd90;
			MON_MAY: n = 9'd120;
			MON_JUN: n = 9'd151;
			MON_JUL: n = 9'd181;
			MON_AUG: n = 9'd212;
			MON_SEP: n = 9'd243;
			MON_OCT: n = 9'd273;
			MON_NOV: n = 9'd304;
			MON_DEC: n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

[rtl/ddd_day_number.sv]
// ddd_day_number: three-stage validity check and day number of one date
// depends on ddd_pkg; stage enables come from the top level
module ddd_day_number import ddd_pkg::*; (
	input  logic              clk,
	input  ddd_stage_en_t     en,
	input  logic [DAY_W-1:0]  day,
	input  logic [MON_W-1:0]  month,
	input  logic [YEAR_W-1:0] year,
	output logic              ok_s3,
	output logic [DN_W-1:0]   dnum_s3
);

	logic [DAY_W-1:0]  d_s1, d_s2;
	logic [MON_W-1:0]  m_s1, m_s2;
	logic [YEAR_W-1:0] p_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              range_ok_s1;
	logic              ok_s2, leap_s2;
	logic [DN_W-1:0]   part_s2;

	logic [YEAR_W-1:0] p_c, q100_c, r_c;
	logic [QUO_W-1:0]  q_c, qp1_c;
	logic              range_ok_c, leap_c, ok_c;
	logic [DN_W-1:0]   part_c, dnum_c;

	// stage 1: range checks, year minus one, reciprocal product
	assign p_c = year - 14'd1;
	assign range_ok_c = (day != '0) && (month >= MON_JAN) && (month <= MON_DEC) &&
		(year != '0) && (year <= YEAR_W'(MAX_YEAR));

	always_ff @(posedge clk) begin
		if (en.s1) begin
			d_s1        <= day;
			m_s1        <= month;
			p_s1        <= p_c;
			prod_s1     <= PROD_W'(p_c) * PROD_W'(RECIP_100);
			range_ok_s1 <= range_ok_c;
		end
	end

	// stage 2: quotient by 100, leap year, month length, year part of day number
	assign q_c    = prod_s1[RECIP_SHIFT +: QUO_W];
	assign qp1_c  = q_c + 8'd1;
	assign q100_c = YEAR_W'(q_c) * 14'd100;
	assign r_c    = p_s1 - q100_c;
	assign leap_c = ((p_s1[1:0] == 2'd3) && (r_c != 14'd99)) ||
		((r_c == 14'd99) && (qp1_c[1:0] == 2'd0));
	assign ok_c   = range_ok_s1 && (d_s1 <= month_len(m_s1, leap_c));
	assign part_c = DN_W'(p_s1) * 23'd365 + DN_W'(p_s1[YEAR_W-1:2]) - DN_W'(q_c) +
		DN_W'(q_c[QUO_W-1:2]);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			d_s2    <= d_s1;
			m_s2    <= m_s1;
			ok_s2   <= ok_c;
			leap_s2 <= leap_c;
			part_s2 <= part_c;
		end
	end

	// stage 3: month and day part
	assign dnum_c = part_s2 + DN_W'(days_before(m_s2)) +
		DN_W'((m_s2 > MON_FEB) && leap_s2) + DN_W'(d_s2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ok_s3   <= ok_s2;
			dnum_s3 <= ok_s2 ? dnum_c : '0;
		end
	end

endmodule

[rtl/date_difference_in_days.sv]
// date_difference_in_days: top level, four-stage pipeline giving the days between two dates
// depends on ddd_pkg and ddd_day_number
//
// Each word carries two Gregorian dates; the result word gives dates_valid and the absolute
// number of days between them, or zero when either date is invalid (day or month zero, month
// above 12, year zero or above 9999, day beyond the month length). A new word is taken every
// cycle while in_stall is low; the four register stages are the range checks with the
// reciprocal multiply by 1/100, the leap year and year part of the day number, the month and
// day part, and the subtraction. Stall on the output halts the pipeline from the last stage
// back; empty stages still take words, so in_stall rises only when all four are full.
module date_difference_in_days import ddd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DAY_W-1:0]  first_day,
	input  logic [MON_W-1:0]  first_month,
	input  logic [YEAR_W-1:0] first_year,
	input  logic [DAY_W-1:0]  second_day,
	input  logic [MON_W-1:0]  second_month,
	input  logic [YEAR_W-1:0] second_year,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              dates_valid,
	output logic [CNT_W-1:0]  day_count
);

	logic          v_s1, v_s2, v_s3, v_s4;
	logic          rdy1, rdy2, rdy3, rdy4;
	ddd_stage_en_t en;

	logic            ok_a_s3, ok_b_s3;
	logic [DN_W-1:0] dn_a_s3, dn_b_s3;
	logic [DN_W-1:0] diff_c;
	logic            both_ok_c;
	logic            sat_c;

	logic             dates_valid_s4;
	logic [CNT_W-1:0] day_count_s4;

	assign rdy4 = !v_s4 || !out_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign en.s1 = rdy1;
	assign en.s2 = rdy2;
	assign en.s3 = rdy3;

	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	ddd_day_number u_first (
		.clk     (clk),
		.en      (en),
		.day     (first_day),
		.month   (first_month),
		.year    (first_year),
		.ok_s3   (ok_a_s3),
		.dnum_s3 (dn_a_s3)
	);

	ddd_day_number u_second (
		.clk     (clk),
		.en      (en),
		.day     (second_day),
		.month   (second_month),
		.year    (second_year),
		.ok_s3   (ok_b_s3),
		.dnum_s3 (dn_b_s3)
	);

	// stage 4: absolute difference, zero for an invalid pair
	assign both_ok_c = ok_a_s3 && ok_b_s3;
	assign diff_c    = (dn_a_s3 > dn_b_s3) ? (dn_a_s3 - dn_b_s3) : (dn_b_s3 - dn_a_s3);
	// clamp to the count width
	assign sat_c     = diff_c > DN_W'({CNT_W{1'b1}});

	always_ff @(posedge clk) begin
		if (rdy4) begin
			dates_valid_s4 <= both_ok_c;
			day_count_s4   <= both_ok_c ? (sat_c ? '1 : diff_c[CNT_W-1:0]) : '0;
		end
	end

	assign out_valid   = v_s4;
	assign dates_valid = dates_valid_s4;
	assign day_count   = day_count_s4;

	// checks
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_stall))
		else $error("input stalled with room in the pipeline");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !dates_valid) |-> (day_count == '0))
		else $error("invalid pair gave a nonzero count");

	a_word_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && out_valid && out_stall) |=> (v_s3 && out_valid))
		else $error("word lost while stalled");

endmodule

[sim/tb.sv]
// tb: self-checking testbench for date_difference_in_days, directed table then random date pairs
// depends on ddd_pkg and the date_difference_in_days rtl; predicts each result word independently
`timescale 1ns / 1ps

module tb;
	import ddd_pkg::*;

	localparam int          N_DIR     = 25;
	localparam int          N_RANDOM  = 1950;
	localparam int          LIMIT     = 400000;
	localparam int unsigned COUNT_CAP = (1 << CNT_W) - 1;
	localparam int unsigned YEAR_TOP  = (1 << YEAR_W) - 1;

	typedef struct packed {
		logic [DAY_W-1:0]  d1;
		logic [MON_W-1:0]  m1;
		logic [YEAR_W-1:0] y1;
		logic [DAY_W-1:0]  d2;
		logic [MON_W-1:0]  m2;
		logic [YEAR_W-1:0] y2;
	} date_pair_t;

	typedef struct packed {
		logic             ok;
		logic [CNT_W-1:0] count;
	} span_t;

	typedef struct packed {
		date_pair_t pair;
		logic       typed;
		span_t      want;
	} dir_row_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [DAY_W-1:0]  first_day    = '0;
	logic [MON_W-1:0]  first_month  = '0;
	logic [YEAR_W-1:0] first_year   = '0;
	logic [DAY_W-1:0]  second_day   = '0;
	logic [MON_W-1:0]  second_month = '0;
	logic [YEAR_W-1:0] second_year  = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic              dates_valid;
	logic [CNT_W-1:0]  day_count;

	span_t       pending_spans [$];
	span_t       got_span;
	int unsigned errors      = 0;
	int unsigned words_sent  = 0;
	int unsigned burst_left  = 0;
	int unsigned cycles      = 0;

	// typed rows carry their expected word, the others go through the predictor
	dir_row_t dir_rows [N_DIR] = '{
		'{'{5'd0, 4'd0, 14'd0, 5'd0, 4'd0, 14'd0}, 1'b1, '{1'b0, 22'd0}},
		'{'{5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383}, 1'b1, '{1'b0, 22'd0}},
		'{'{5'd1, MON_JAN, 14'd1, 5'd31, MON_DEC, 14'd9999}, 1'b1, '{1'b1, 22'd3652058}},
		'{'{5'd31, MON_DEC, 14'd9999, 5'd1, MON_JAN, 14'd1}, 1'b1, '{1'b1, 22'd3652058}},
		'{'{5'd1, MON_JAN, 14'd2000, 5'd1, MON_JAN, 14'd2000}, 1'b1, '{1'b1, 22'd0}},
		'{'{5'd1, MON_JAN, 14'd9999, 5'd31, MON_DEC, 14'd9999}, 1'b1, '{1'b1, 22'd364}},
		'{'{5'd1, MON_JAN, 14'd1, 5'd1, MON_JAN, 14'd2}, 1'b1, '{1'b1, 22'd365}},
		'{'{5'd1, MON_JAN, 14'd2001, 5'd1, MON_JAN, 14'd2000}, 1'b1, '{1'b1, 22'd366}},
		'{'{5'd28, MON_FEB, 14'd2024, 5'd29, MON_FEB, 14'd2024}, 1'b1, '{1'b1, 22'd1}},
		'{'{5'd29, MON_FEB, 14'd2000, 5'd1, MON_MAR, 14'd2000}, 1'b1, '{1'b1, 22'd1}},
		'{'{5'd1, MON_MAR, 14'd2400, 5'd29, MON_FEB, 14'd2400}, 1'b1, '{1'b1, 22'd1}},
		'{'{5'd31, MON_DEC, 14'd2023, 5'd1, MON_JAN, 14'd2024}, 1'b1, '{1'b1, 22'd1}},
		'{'{5'd29, MON_FEB, 14'd1900, 5'd1, MON_JAN, 14'd1900}, 1'b1, '{1'b0, 22'd0}},
		'{'{5'd1, MON_JAN, 14'd2100, 5'd29, MON_FEB, 14'd2100}, 1'b1, '{1'b0, 22'd0}},
		'{'{5'd30, MON_FEB, 14'd2024, 5'd1, MON_JAN, 14'd2024}, 1'b1, '{1'b0, 22'd0}},
		'{'{5'd31, MON_APR, 14'd2023, 5'd1, MON_MAY, 14'd2023}, 1'b1, '{1'b0, 22'd0}},
		'{'{5'd1, 4'd13, 14'd2023, 5'd1, MON_MAY, 14'd2023}, 1'b1, '{1'b0, 22'd0}},
		'{'{5'd1, MON_JAN, 14'd2023, 5'd1, 4'd0, 14'd2023}, 1'b1, '{1'b0, 22'd0}},
		'{'{5'd1, MON_JAN, 14'd0, 5'd1, MON_JAN, 14'd2023}, 1'b1, '{1'b0, 22'd0}},
		'{'{5'd1, MON_JAN, 14'd2023, 5'd1, MON_JAN, 14'd10000}, 1'b1, '{1'b0, 22'd0}},
		'{'{5'd0, MON_JUN, 14'd2000, 5'd31, MON_JUN, 14'd2000}, 1'b1, '{1'b0, 22'd0}},
		'{'{5'd15, MON_AUG, 14'd1947, 5'd26, MON_JAN, 14'd1950}, 1'b0, '{1'b0, 22'd0}},
		'{'{5'd31, MON_JAN, 14'd2024, 5'd1, MON_MAR, 14'd2023}, 1'b0, '{1'b0, 22'd0}},
		'{'{5'd1, MON_MAR, 14'd1600, 5'd28, MON_FEB, 14'd1700}, 1'b0, '{1'b0, 22'd0}},
		'{'{5'd7, MON_NOV, 14'd5000, 5'd3, MON_MAY, 14'd123}, 1'b0, '{1'b0, 22'd0}}
	};

	date_difference_in_days DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first_day    (first_day),
		.first_month  (first_month),
		.first_year   (first_year),
		.second_day   (second_day),
		.second_month (second_month),
		.second_year  (second_year),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.dates_valid  (dates_valid),
		.day_count    (day_count)
	);

	always #2 clk = ~clk;

	function automatic int unsigned days_in_month(input logic [MON_W-1:0] m,
		input logic [YEAR_W-1:0] y);
		logic leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			MON_FEB: return leap ? 29 : 28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic logic date_is_valid(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
		input logic [YEAR_W-1:0] y);
		if (d == 0 || m == 0 || m > MON_DEC || y == 0 || y > MAX_YEAR)
			return 1'b0;
		return d <= days_in_month(m, y);
	endfunction

	// day number with the first of january of year one as day one
	function automatic int unsigned serial_day(input logic [DAY_W-1:0] d,
		input logic [MON_W-1:0] m, input logic [YEAR_W-1:0] y);
		int unsigned p;
		int unsigned n;
		p = y - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400;
		for (logic [MON_W-1:0] mm = MON_JAN; mm < m; mm++)
			n += days_in_month(mm, y);
		return n + d;
	endfunction

	function automatic span_t days_between(input date_pair_t p);
		span_t       s;
		int unsigned a;
		int unsigned b;
		int unsigned diff;
		s = '0;
		if (date_is_valid(p.d1, p.m1, p.y1) && date_is_valid(p.d2, p.m2, p.y2)) begin
			a = serial_day(p.d1, p.m1, p.y1);
			b = serial_day(p.d2, p.m2, p.y2);
			diff = (a > b) ? a - b : b - a;
			if (diff > COUNT_CAP)
				diff = COUNT_CAP;
			s.ok = 1'b1;
			s.count = diff[CNT_W-1:0];
		end
		return s;
	endfunction

	function automatic void pick_date(output logic [DAY_W-1:0] d, output logic [MON_W-1:0] m,
		output logic [YEAR_W-1:0] y);
		int unsigned len;
		case ($urandom_range(0, 7))
			0: y = YEAR_W'($urandom_range(1, 4));
			1: y = YEAR_W'($urandom_range(MAX_YEAR - 3, MAX_YEAR));
			2: y = YEAR_W'(100 * $urandom_range(1, 99));
			default: y = YEAR_W'($urandom_range(1, MAX_YEAR));
		endcase
		m = MON_W'($urandom_range(MON_JAN, MON_DEC));
		len = days_in_month(m, y);
		d = ($urandom_range(0, 5) == 0) ? DAY_W'(len) : DAY_W'($urandom_range(1, len));
	endfunction

	function automatic void spoil_date(inout logic [DAY_W-1:0] d, inout logic [MON_W-1:0] m,
		inout logic [YEAR_W-1:0] y);
		int unsigned len;
		len = days_in_month(m, y);
		case ($urandom_range(0, 3))
			0: d = '0;
			1: m = ($urandom_range(0, 1) != 0) ? '0 : MON_W'($urandom_range(13, 15));
			2: y = ($urandom_range(0, 1) != 0) ? '0 :
				YEAR_W'($urandom_range(MAX_YEAR + 1, YEAR_TOP));
			default: d = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
		endcase
	endfunction

	function automatic date_pair_t random_pair();
		date_pair_t  p;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		pick_date(p.d1, p.m1, p.y1);
		pick_date(p.d2, p.m2, p.y2);
		if (kind < 25) begin
			// same or next year for short spans
			p.y2 = p.y1 + YEAR_W'($urandom_range(0, 1));
			if (p.y2 > MAX_YEAR)
				p.y2 = p.y1;
			if (p.d2 > days_in_month(p.m2, p.y2))
				p.d2 = 5'd28;
		end else if (kind < 37) begin
			if ($urandom_range(0, 1) != 0)
				spoil_date(p.d1, p.m1, p.y1);
			else
				spoil_date(p.d2, p.m2, p.y2);
		end else if (kind < 45) begin
			p.d1 = DAY_W'($urandom_range(0, 31));
			p.m1 = MON_W'($urandom_range(0, 15));
			p.y1 = YEAR_W'($urandom_range(0, YEAR_TOP));
			p.d2 = DAY_W'($urandom_range(0, 31));
			p.m2 = MON_W'($urandom_range(0, 15));
			p.y2 = YEAR_W'($urandom_range(0, YEAR_TOP));
		end
		return p;
	endfunction

	task automatic offer(input date_pair_t p, input span_t w);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		first_day    <= p.d1;
		first_month  <= p.m1;
		first_year   <= p.y1;
		second_day   <= p.d2;
		second_month <= p.m2;
		second_year  <= p.y2;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_spans.push_back(w);
		words_sent++;
	endtask

	// receiver: changing stall patterns plus one long hold-off to fill the pipeline
	initial begin
		int unsigned mode;
		int unsigned left;
		int unsigned hold;
		logic        held_off;
		mode = 0;
		left = 0;
		hold = 0;
		held_off = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(10, 80);
			end
			left--;
			if (!held_off && words_sent >= 500) begin
				held_off = 1'b1;
				hold = 200;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= ((left & 2) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_spans.size() == 0) begin
				$error("result word with none expected: dates_valid %0d day_count %0d",
					dates_valid, day_count);
				errors++;
			end else begin
				got_span = pending_spans.pop_front();
				if (dates_valid !== got_span.ok) begin
					$error("dates_valid expected %0d got %0d", got_span.ok, dates_valid);
					errors++;
				end
				if (day_count !== got_span.count) begin
					$error("day_count expected %0d got %0d", got_span.count, day_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk)
		cycles <= cycles + 1;

	initial begin
		while (cycles < LIMIT)
			@(posedge clk);
		$display("[date_difference_in_days] ERROR");
		$finish;
	end

	initial begin
		date_pair_t p;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_DIR; i++)
			offer(dir_rows[i].pair,
				dir_rows[i].typed ? dir_rows[i].want : days_between(dir_rows[i].pair));
		for (int i = 0; i < N_RANDOM; i++) begin
			p = random_pair();
			offer(p, days_between(p));
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_spans.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("[date_difference_in_days] OK");
		else
			$display("[date_difference_in_days] ERROR");
		$finish;
	end

endmodule
